>>> src/incubator_heat_cool_regulator_top_defines.svh
// Assertion macros shared by the regulator modules.
`ifndef INCUBATOR_HEAT_COOL_REGULATOR_TOP_DEFINES_SVH
`define INCUBATOR_HEAT_COOL_REGULATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during rst.
`define IHCR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ihcr check failed");

// Next-cycle implication, sampled on clk and quiet during rst.
`define IHCR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ihcr check failed");

`endif

>>> src/ihcr_pkg.sv
// Types, constants and helper functions of the incubator heat/cool regulator.
package ihcr_pkg;

  localparam int TEMP_W     = 12;
  localparam int DIFF_W     = TEMP_W + 1;
  localparam int CMP_W      = (DIFF_W + 1 > 14) ? DIFF_W + 1 : 14;
  localparam int LVL_W      = 8;
  localparam int ERR_W      = 12;
  localparam int SQ_W       = 2 * ERR_W;
  localparam int NUM_W      = SQ_W + LVL_W;
  localparam int MSQ_W      = 16;
  localparam int DEN_W      = MSQ_W + 7;
  localparam int BIT_CNT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TEMP_W;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SET_TEMP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_POWER_DEV = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EGG_ON         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EGG_OFF        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERCENT    = 3'd5;

  localparam logic [LVL_W-1:0] LVL_OFF  = 8'h00;
  localparam logic [LVL_W-1:0] LVL_FULL = 8'hFF;

  // Reciprocal of 100 scaled by 2^19, exact for the min_percent range.
  localparam logic [12:0] RECIP_100 = 13'd5243;

  typedef enum logic [1:0] {
    OP_ZERO,
    OP_FULL,
    OP_QUAD,
    OP_HOLD
  } op_t;

  typedef struct packed {
    logic                     func;
    logic signed [TEMP_W-1:0] air_temp;
    logic signed [TEMP_W-1:0] egg_temp;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] fan_power;
    logic [LVL_W-1:0] heater_power;
    logic             egg_overheat;
  } out_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] set_temp;
    logic [7:0]               full_power_dev;
    logic [7:0]               dead_band;
    logic [7:0]               egg_on;
    logic [7:0]               egg_off;
    logic [6:0]               min_percent;
  } cfg_t;

  typedef struct packed {
    op_t              fan_op;
    logic [ERR_W-1:0] fan_err;
    op_t              heat_op;
    logic [ERR_W-1:0] heat_err;
    logic             overheat;
  } cmd_t;

  // Sorts a signed error into the four zones of the drive law.
  function automatic op_t classify(input logic signed [CMP_W-1:0] x,
                                   input logic [7:0] m, input logic [7:0] db);
    logic signed [CMP_W-1:0] lim;
    op_t                     op;
    lim = $signed(CMP_W'({m, 3'b000}) + CMP_W'({m, 1'b0}));
    priority if (x[CMP_W-1] || x == '0) begin
      op = OP_ZERO;
    end else if (x >= lim) begin
      op = OP_FULL;
    end else if (x > $signed(CMP_W'(db))) begin
      op = OP_QUAD;
    end else begin
      op = OP_HOLD;
    end
    return op;
  endfunction

  // Lowest drive in the quadratic zone: floor(mp * 255 / 100), capped at full.
  function automatic logic [LVL_W-1:0] floor_level(input logic [6:0] mp);
    logic [14:0] prod;
    logic [27:0] scaled;
    logic [8:0]  q;
    prod   = {mp, 8'b0} - {8'b0, mp};
    scaled = 28'(prod) * 28'(RECIP_100);
    q      = scaled[27:19];
    return q[8] ? LVL_FULL : q[7:0];
  endfunction

endpackage

>>> src/incubator_heat_cool_regulator_top.sv
// Each accepted request passes through the queue to the drive unit, which applies the fan and then
// the heater command; each drive in the quadratic zone also runs the shared square-and-divide unit.
// The drive unit starts a command only once the previous result has been taken, so it takes no new
// command before it is through with the last one. The front end fills a two-entry queue meanwhile.
// Synchronous active-high reset: latch and drive levels cleared, registers to their defaults.
// Configuration writes are taken in the cycle they are offered.
module incubator_heat_cool_regulator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ihcr_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ihcr_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ihcr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ihcr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ihcr_pkg::*;

  // Configuration registers. The user must change them only while the block is idle; the block
  // does not enforce this. The front end and the drive unit read them directly without shadowing.
  cfg_t cfg;

  // Command path from the classifier to the drive unit.
  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  // Writes always complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_temp       <= TEMP_W'(375);
      cfg.full_power_dev <= 8'd1;
      cfg.dead_band      <= 8'd1;
      cfg.egg_on         <= 8'd5;
      cfg.egg_off        <= 8'd2;
      cfg.min_percent    <= 7'd0;
    end else if (cfg_valid && cfg_ready) begin
      // Indexes past the last register are dropped.
      unique case (cfg_index)
        REG_SET_TEMP:       cfg.set_temp       <= $signed(cfg_data[TEMP_W-1:0]);
        REG_FULL_POWER_DEV: cfg.full_power_dev <= cfg_data[7:0];
        REG_DEAD_BAND:      cfg.dead_band      <= cfg_data[7:0];
        REG_EGG_ON:         cfg.egg_on         <= cfg_data[7:0];
        REG_EGG_OFF:        cfg.egg_off        <= cfg_data[7:0];
        REG_MIN_PERCENT:    cfg.min_percent    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // The front end decides the overheat latch and the zone of each drive in the
  // accepting cycle, so the latch is always current for the next request.
  ihcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ihcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The drive unit owns the held fan and heater levels and the output register.
  ihcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd_data  (pop_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> src/ihcr_front.sv
// Front end: accepts samples, runs the overheat latch and classifies both drives.
module ihcr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ihcr_pkg::in_item_t in_data,
  input  ihcr_pkg::cfg_t     cfg,
  output logic               push_valid,
  input  logic               push_ready,
  output ihcr_pkg::cmd_t     push_data
);
  import ihcr_pkg::*;

  logic                    latch;
  logic                    latch_next;
  logic signed [CMP_W-1:0] air_x;
  logic signed [CMP_W-1:0] egg_x;
  logic signed [CMP_W-1:0] set_x;
  logic signed [CMP_W-1:0] a;
  logic signed [CMP_W-1:0] e;
  logic signed [CMP_W-1:0] d;
  logic signed [CMP_W-1:0] egg_on_x;
  logic signed [CMP_W-1:0] egg_off_x;
  logic                    latch_kept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    air_x     = {{(CMP_W-TEMP_W){in_data.air_temp[TEMP_W-1]}}, in_data.air_temp};
    egg_x     = {{(CMP_W-TEMP_W){in_data.egg_temp[TEMP_W-1]}}, in_data.egg_temp};
    set_x     = {{(CMP_W-TEMP_W){cfg.set_temp[TEMP_W-1]}}, cfg.set_temp};
    a         = air_x - set_x;
    e         = egg_x - set_x;
    d         = set_x - air_x;
    egg_on_x  = $signed(CMP_W'(cfg.egg_on));
    egg_off_x = $signed(CMP_W'(cfg.egg_off));

    latch_kept = latch && !(e < egg_off_x);
    push_data.fan_err  = a[ERR_W-1:0];
    push_data.heat_err = d[ERR_W-1:0];

    if (in_data.func) begin
      latch_next        = latch;
      push_data.fan_op  = OP_ZERO;
      push_data.heat_op = OP_ZERO;
    end else begin
      if (e > egg_on_x || latch_kept) begin
        latch_next       = 1'b1;
        push_data.fan_op = OP_FULL;
      end else begin
        latch_next       = 1'b0;
        push_data.fan_op = classify(a, cfg.full_power_dev, cfg.dead_band);
      end
      // The heater stays off while the egg runs warmer than the release limit.
      if (e > egg_off_x) begin
        push_data.heat_op = OP_ZERO;
      end else begin
        push_data.heat_op = classify(d, cfg.full_power_dev, cfg.dead_band);
      end
    end
    push_data.overheat = latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch <= 1'b0;
    end else if (in_valid && push_ready) begin
      latch <= latch_next;
    end
  end

endmodule

>>> src/ihcr_queue.sv
// Two-entry command queue between the front end and the drive unit.
`include "incubator_heat_cool_regulator_top_defines.svh"

module ihcr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  ihcr_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ihcr_pkg::cmd_t pop_data
);
  import ihcr_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count < QCNT_W'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `IHCR_ASSERT_IMPL(q_count_bound, 1'b1, count <= QCNT_W'(QDEPTH))
  `IHCR_ASSERT_NEXT(q_fill_step, push && !pop, count == $past(count) + 1'b1)
  `IHCR_ASSERT_NEXT(q_drain_step, pop && !push, count == $past(count) - 1'b1)

endmodule

>>> src/ihcr_back.sv
// Drive unit: applies each command to the held levels through a shared square-and-divide path.
`include "incubator_heat_cool_regulator_top_defines.svh"

module ihcr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ihcr_pkg::cmd_t      cmd_data,
  input  ihcr_pkg::cfg_t      cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output ihcr_pkg::out_item_t out_data
);
  import ihcr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_APPLY = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]           state;
  logic                 sel;
  cmd_t                 work;
  logic [LVL_W-1:0]     fan_level;
  logic [LVL_W-1:0]     heater_level;
  logic [SQ_W-1:0]      sq;
  logic [MSQ_W-1:0]     msq;
  logic [NUM_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [LVL_W-1:0]     quot;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [LVL_W-1:0]     floor_q;

  op_t              cur_op;
  logic [ERR_W-1:0] cur_err;
  logic [LVL_W-1:0] cur_level;
  logic [LVL_W-1:0] direct_level;
  logic [LVL_W-1:0] quad_level;
  logic [NUM_W-1:0] shifted;

  assign cmd_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    cur_op     = sel ? work.heat_op : work.fan_op;
    cur_err    = sel ? work.heat_err : work.fan_err;
    cur_level  = sel ? heater_level : fan_level;
    shifted    = NUM_W'(den) << bit_cnt;
    quad_level = (quot < floor_q) ? floor_q : quot;
    unique case (cur_op)
      OP_ZERO: direct_level = LVL_OFF;
      OP_FULL: direct_level = LVL_FULL;
      default: direct_level = cur_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sel          <= 1'b0;
      fan_level    <= LVL_OFF;
      heater_level <= LVL_OFF;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            work  <= cmd_data;
            sel   <= 1'b0;
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (cur_op == OP_QUAD) begin
            sq      <= SQ_W'(cur_err) * SQ_W'(cur_err);
            msq     <= MSQ_W'(cfg.full_power_dev) * MSQ_W'(cfg.full_power_dev);
            floor_q <= floor_level(cfg.min_percent);
            state   <= ST_SCALE;
          end else begin
            if (sel) begin
              heater_level <= direct_level;
              state        <= ST_DONE;
            end else begin
              fan_level <= direct_level;
              sel       <= 1'b1;
            end
          end
        end
        ST_SCALE: begin
          // Numerator err^2 * 255, denominator M^2 * 100.
          rem     <= {sq, 8'b0} - {8'b0, sq};
          den     <= DEN_W'({msq, 6'b0}) + DEN_W'({msq, 5'b0}) + DEN_W'({msq, 2'b0});
          quot    <= '0;
          bit_cnt <= '1;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (rem >= shifted) begin
            rem           <= rem - shifted;
            quot[bit_cnt] <= 1'b1;
          end
          if (bit_cnt == '0) begin
            state <= ST_WRITE;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        ST_WRITE: begin
          if (sel) begin
            heater_level <= quad_level;
            state        <= ST_DONE;
          end else begin
            fan_level <= quad_level;
            sel       <= 1'b1;
            state     <= ST_APPLY;
          end
        end
        ST_DONE: begin
          out_valid             <= 1'b1;
          out_data.fan_power    <= fan_level;
          out_data.heater_power <= heater_level;
          out_data.egg_overheat <= work.overheat;
          state                 <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `IHCR_ASSERT_IMPL(bk_done_slot_free, state == ST_DONE, !out_valid)
  `IHCR_ASSERT_IMPL(bk_div_remainder, state == ST_WRITE, rem < NUM_W'(den))
  `IHCR_ASSERT_NEXT(bk_quad_entry, (state == ST_APPLY) && (cur_op == OP_QUAD), state == ST_SCALE)

endmodule
